### hw/rtl/bfsa_pkg.sv
`timescale 1ns / 1ps

package bfsa_pkg;

	// Table geometry and field widths.
	localparam int SEG_DEPTH = 64;
	localparam int IDX_W = $clog2(SEG_DEPTH);
	localparam int CNT_W = $clog2(SEG_DEPTH + 1);
	localparam int SIZE_W = 16;
	localparam int ID_W = 8;

	// Disk size after reset.
	localparam logic [SIZE_W-1:0] RESET_DISK = SIZE_W'(1000);

	// Result status codes.
	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_NOFIT = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	// Request kinds.
	localparam logic KIND_CREATE = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	// One segment table entry; owner zero marks a free segment.
	typedef struct packed {
		logic [ID_W-1:0]   owner;
		logic [SIZE_W-1:0] start;
		logic [SIZE_W-1:0] size;
	} seg_entry_t;

	// Write port request toward the segment memory.
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  addr;
		seg_entry_t        data;
	} seg_wr_t;

endpackage

### hw/rtl/best_fit_segment_allocator_core.sv
`timescale 1ns / 1ps
// Requests are taken one at a time: a new request stalls until the last
// result has been taken. The segment memory is swept once for a scan, once
// more for an entry shift when a create splits a segment, and once for a delete.
// Reset (arst_n low) sets the disk size to 1000 with one free segment;
// a disk size write restores a one-segment table of the written size at once.
module best_fit_segment_allocator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bfsa_pkg::SIZE_W-1:0]    cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           kind,
	input  logic [bfsa_pkg::ID_W-1:0]      file_id,
	input  logic [bfsa_pkg::SIZE_W-1:0]    file_size,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [bfsa_pkg::SIZE_W-1:0]    free_total
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_SCAN    = 7'b0000010,
		ST_DECIDE  = 7'b0000100,
		ST_SHIFT   = 7'b0001000,
		ST_TAIL    = 7'b0010000,
		ST_DEL     = 7'b0100000,
		ST_DEL_END = 7'b1000000
	} state_t;

	state_t                          state_q;
	logic [bfsa_pkg::SIZE_W-1:0]     disk_q;
	logic [bfsa_pkg::SIZE_W-1:0]     free_q;
	logic [bfsa_pkg::CNT_W-1:0]      seg_count_q;
	logic                            v0_q;
	logic [bfsa_pkg::ID_W-1:0]       req_id_q;
	logic [bfsa_pkg::SIZE_W-1:0]     req_size_q;
	logic [bfsa_pkg::CNT_W-1:0]      iss_q;
	logic                            rd_vld_s1;
	logic [bfsa_pkg::IDX_W-1:0]      rd_idx_s1;
	logic                            rd_v0_s1;
	logic                            found_q;
	logic [bfsa_pkg::IDX_W-1:0]      best_idx_q;
	bfsa_pkg::seg_entry_t            best_q;
	logic                            matched_q;
	bfsa_pkg::seg_entry_t            pend_q;
	logic                            pend_vld_q;
	logic [bfsa_pkg::IDX_W-1:0]      wr_idx_q;
	logic                            out_valid_q;
	logic [1:0]                      status_q;

	logic                            rd_issue;
	logic [bfsa_pkg::IDX_W-1:0]      raddr;
	bfsa_pkg::seg_entry_t            ram_rdata;
	bfsa_pkg::seg_entry_t            rd_eff;
	bfsa_pkg::seg_entry_t            del_ent;
	logic                            del_match;
	logic                            del_merge;
	logic                            del_flush;
	bfsa_pkg::seg_wr_t               wr;
	logic [bfsa_pkg::SIZE_W-1:0]     rest;
	logic                            split;
	logic                            fit_ok;
	logic [bfsa_pkg::CNT_W-1:0]      best_next;
	logic                            in_xfer;

	// Segment memory.
	bfsa_ram #(
		.WIDTH ($bits(bfsa_pkg::seg_entry_t)),
		.DEPTH (bfsa_pkg::SEG_DEPTH)
	) u_seg_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// A disk size write takes the cycle, so no request transfer goes with it.
	assign in_stall = (state_q != ST_IDLE) || out_valid_q || cfg_we;
	assign in_xfer = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign free_total = free_q;

	// Entry 0 reads as the initial free segment until it is first written.
	always_comb begin
		rd_eff = ram_rdata;
		if (rd_idx_s1 == '0 && !rd_v0_s1) begin
			rd_eff.owner = '0;
			rd_eff.start = '0;
			rd_eff.size = disk_q;
		end
	end

	// Decision terms for the chosen segment.
	assign rest = best_q.size - req_size_q;
	assign split = (rest != '0);
	assign fit_ok = found_q && !(split && seg_count_q == bfsa_pkg::CNT_W'(bfsa_pkg::SEG_DEPTH));
	assign best_next = bfsa_pkg::CNT_W'(best_idx_q) + bfsa_pkg::CNT_W'(1);

	// Read issue: forward sweep for scan and delete, backward for the shift.
	always_comb begin
		rd_issue = 1'b0;
		raddr = iss_q[bfsa_pkg::IDX_W-1:0];
		case (state_q)
			ST_SCAN, ST_DEL: begin
				rd_issue = (iss_q < seg_count_q);
			end
			ST_SHIFT: begin
				rd_issue = (iss_q > best_next);
				raddr = iss_q[bfsa_pkg::IDX_W-1:0] - bfsa_pkg::IDX_W'(1);
			end
			default: begin
				rd_issue = 1'b0;
			end
		endcase
	end

	// Delete stream: free the first match, then fold adjacent free entries.
	always_comb begin
		del_ent = rd_eff;
		del_match = !matched_q && (req_id_q != '0) && (rd_eff.owner == req_id_q);
		if (del_match) begin
			del_ent.owner = '0;
		end
		del_merge = pend_vld_q && (pend_q.owner == '0) && (del_ent.owner == '0);
		del_flush = pend_vld_q && !del_merge;
	end

	// Write port selection.
	always_comb begin
		wr.we = 1'b0;
		wr.addr = best_idx_q;
		wr.data = pend_q;
		case (state_q)
			ST_DECIDE: begin
				wr.we = fit_ok;
				wr.data.owner = req_id_q;
				wr.data.start = best_q.start;
				wr.data.size = req_size_q;
			end
			ST_SHIFT: begin
				wr.we = rd_vld_s1;
				wr.addr = rd_idx_s1 + bfsa_pkg::IDX_W'(1);
				wr.data = rd_eff;
			end
			ST_TAIL: begin
				wr.we = 1'b1;
				wr.addr = best_idx_q + bfsa_pkg::IDX_W'(1);
				wr.data.owner = '0;
				wr.data.start = best_q.start + req_size_q;
				wr.data.size = rest;
			end
			ST_DEL: begin
				wr.we = rd_vld_s1 && del_flush;
				wr.addr = wr_idx_q;
			end
			ST_DEL_END: begin
				wr.we = 1'b1;
				wr.addr = wr_idx_q;
			end
			default: begin
				wr.we = 1'b0;
			end
		endcase
	end

	// Read pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= raddr;
		rd_v0_s1 <= v0_q;
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			disk_q <= bfsa_pkg::RESET_DISK;
			free_q <= bfsa_pkg::RESET_DISK;
			seg_count_q <= bfsa_pkg::CNT_W'(1);
			v0_q <= 1'b0;
			out_valid_q <= 1'b0;
			status_q <= bfsa_pkg::STATUS_DONE;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (wr.we && wr.addr == '0) begin
				v0_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						disk_q <= cfg_wdata;
						free_q <= cfg_wdata;
						seg_count_q <= bfsa_pkg::CNT_W'(1);
						v0_q <= 1'b0;
					end else if (in_xfer) begin
						if (kind == bfsa_pkg::KIND_DELETE) begin
							state_q <= ST_DEL;
						end else if (file_id == '0 || file_size == '0) begin
							status_q <= bfsa_pkg::STATUS_NOFIT;
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (!rd_issue && !rd_vld_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!found_q) begin
						status_q <= bfsa_pkg::STATUS_NOFIT;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else if (!fit_ok) begin
						status_q <= bfsa_pkg::STATUS_FULL;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						free_q <= free_q - req_size_q;
						if (split) begin
							state_q <= ST_SHIFT;
						end else begin
							status_q <= bfsa_pkg::STATUS_DONE;
							out_valid_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SHIFT: begin
					if (!rd_issue && !rd_vld_s1) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					seg_count_q <= seg_count_q + bfsa_pkg::CNT_W'(1);
					status_q <= bfsa_pkg::STATUS_DONE;
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_DEL: begin
					if (rd_vld_s1 && del_match) begin
						free_q <= free_q + rd_eff.size;
					end
					if (!rd_issue && !rd_vld_s1) begin
						state_q <= ST_DEL_END;
					end
				end
				ST_DEL_END: begin
					seg_count_q <= bfsa_pkg::CNT_W'(wr_idx_q) + bfsa_pkg::CNT_W'(1);
					status_q <= bfsa_pkg::STATUS_DONE;
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture, sweep counters, best-fit search and delete compaction.
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			iss_q <= (state_q == ST_SHIFT) ? iss_q - bfsa_pkg::CNT_W'(1)
				: iss_q + bfsa_pkg::CNT_W'(1);
		end
		case (state_q)
			ST_IDLE: begin
				req_id_q <= file_id;
				req_size_q <= file_size;
				iss_q <= '0;
				found_q <= 1'b0;
				matched_q <= 1'b0;
				pend_vld_q <= 1'b0;
				wr_idx_q <= '0;
			end
			ST_SCAN: begin
				if (rd_vld_s1 && rd_eff.owner == '0 && rd_eff.size >= req_size_q
						&& (!found_q || rd_eff.size < best_q.size)) begin
					found_q <= 1'b1;
					best_idx_q <= rd_idx_s1;
					best_q <= rd_eff;
				end
			end
			ST_DECIDE: begin
				iss_q <= seg_count_q;
			end
			ST_DEL: begin
				if (rd_vld_s1) begin
					if (del_match) begin
						matched_q <= 1'b1;
					end
					pend_vld_q <= 1'b1;
					if (del_merge) begin
						pend_q.size <= pend_q.size + del_ent.size;
					end else begin
						pend_q <= del_ent;
					end
					if (del_flush) begin
						wr_idx_q <= wr_idx_q + bfsa_pkg::IDX_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// The table never goes empty and never exceeds its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		seg_count_q != '0 && seg_count_q <= bfsa_pkg::CNT_W'(bfsa_pkg::SEG_DEPTH))
		else $error("segment count out of range");

	// A finished result waits only while the sequencer is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == ST_IDLE)
		else $error("result pending while a request is in work");

	// Shift writes stay strictly above the chosen segment.
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr.we && state_q == ST_SHIFT) |-> wr.addr > best_idx_q)
		else $error("shift write overlaps the allocated segment");

	// Compaction writes never overtake the entry being read.
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr.we && state_q == ST_DEL) |-> wr.addr < rd_idx_s1)
		else $error("compaction write ahead of read");

endmodule

### hw/rtl/bfsa_ram.sv
`timescale 1ns / 1ps

module bfsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### dv/tb_best_fit_segment_allocator_core.sv
`timescale 1ns / 1ps

module tb_best_fit_segment_allocator_core;

	localparam int STALL_LIMIT = 20000;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [bfsa_pkg::SIZE_W-1:0] cfg_wdata;
	logic                        in_valid;
	logic                        in_stall;
	logic                        kind;
	logic [bfsa_pkg::ID_W-1:0]   file_id;
	logic [bfsa_pkg::SIZE_W-1:0] file_size;
	logic                        out_valid;
	logic                        out_stall;
	logic [1:0]                  status;
	logic [bfsa_pkg::SIZE_W-1:0] free_total;

	best_fit_segment_allocator_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .file_id(file_id), .file_size(file_size),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .free_total(free_total)
	);

	// Expected outcome of one request.
	typedef struct {
		logic [1:0]                  status;
		logic [bfsa_pkg::SIZE_W-1:0] free_total;
	} alloc_result_t;

	alloc_result_t               pending_results[$];
	logic [bfsa_pkg::SIZE_W-1:0] disk_units;
	logic [bfsa_pkg::SIZE_W-1:0] seg_base[bfsa_pkg::SEG_DEPTH];
	logic [bfsa_pkg::SIZE_W-1:0] seg_len[bfsa_pkg::SEG_DEPTH];
	logic [bfsa_pkg::ID_W-1:0]   seg_holder[bfsa_pkg::SEG_DEPTH];
	int                          seg_used;
	int                          error_count;
	int                          requests_sent;
	int                          results_seen;
	int                          full_seen;
	int                          nofit_seen;
	int                          hold_left;
	int                          idle_cycles;
	bit                          gaps_on;
	bit                          stalls_on;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Segment table mirror: restore one free segment covering the disk.
	function automatic void table_restart(logic [bfsa_pkg::SIZE_W-1:0] units);
		disk_units = units;
		for (int k = 0; k < bfsa_pkg::SEG_DEPTH; k++) begin
			seg_base[k] = '0;
			seg_len[k] = '0;
			seg_holder[k] = '0;
		end
		seg_len[0] = units;
		seg_used = 1;
	endfunction

	function automatic logic [bfsa_pkg::SIZE_W-1:0] free_units();
		logic [bfsa_pkg::SIZE_W-1:0] sum;
		sum = '0;
		for (int k = 0; k < seg_used; k++)
			if (seg_holder[k] == '0)
				sum = sum + seg_len[k];
		return sum;
	endfunction

	// Best-fit placement with split of the remainder.
	function automatic logic [1:0] place_file(logic [bfsa_pkg::ID_W-1:0] id,
			logic [bfsa_pkg::SIZE_W-1:0] units);
		int                          best;
		bit                          found;
		logic [bfsa_pkg::SIZE_W-1:0] best_len;
		logic [bfsa_pkg::SIZE_W-1:0] rest;
		best = 0;
		found = 0;
		best_len = '0;
		if (id == '0 || units == '0)
			return bfsa_pkg::STATUS_NOFIT;
		for (int k = 0; k < seg_used; k++) begin
			if (seg_holder[k] == '0 && seg_len[k] >= units
					&& (!found || seg_len[k] < best_len)) begin
				found = 1;
				best = k;
				best_len = seg_len[k];
			end
		end
		if (!found)
			return bfsa_pkg::STATUS_NOFIT;
		rest = best_len - units;
		if (rest != '0 && seg_used >= bfsa_pkg::SEG_DEPTH)
			return bfsa_pkg::STATUS_FULL;
		seg_holder[best] = id;
		seg_len[best] = units;
		if (rest != '0) begin
			for (int k = seg_used; k > best + 1; k--) begin
				seg_base[k] = seg_base[k-1];
				seg_len[k] = seg_len[k-1];
				seg_holder[k] = seg_holder[k-1];
			end
			seg_base[best+1] = seg_base[best] + units;
			seg_len[best+1] = rest;
			seg_holder[best+1] = '0;
			seg_used++;
		end
		return bfsa_pkg::STATUS_DONE;
	endfunction

	// Free the first segment of the owner, then merge adjacent free runs.
	function automatic logic [1:0] release_file(logic [bfsa_pkg::ID_W-1:0] id);
		for (int k = 0; k < seg_used; k++) begin
			if (seg_holder[k] == id) begin
				seg_holder[k] = '0;
				break;
			end
		end
		for (int k = 0; k < seg_used; k++) begin
			if (seg_holder[k] != '0)
				continue;
			while (k + 1 < seg_used && seg_holder[k+1] == '0) begin
				seg_len[k] = seg_len[k] + seg_len[k+1];
				for (int j = k + 1; j + 1 < seg_used; j++) begin
					seg_base[j] = seg_base[j+1];
					seg_len[j] = seg_len[j+1];
					seg_holder[j] = seg_holder[j+1];
				end
				seg_used--;
			end
		end
		return bfsa_pkg::STATUS_DONE;
	endfunction

	// Offer one request, optionally after a gap, and wait for its transfer.
	task automatic send_request(logic k, logic [bfsa_pkg::ID_W-1:0] id,
			logic [bfsa_pkg::SIZE_W-1:0] units);
		alloc_result_t r;
		if (gaps_on && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		file_id <= id;
		file_size <= units;
		do @(posedge clk); while (in_stall);
		r.status = (k == bfsa_pkg::KIND_CREATE) ? place_file(id, units) : release_file(id);
		r.free_total = free_units();
		if (r.status == bfsa_pkg::STATUS_FULL)
			full_seen++;
		if (r.status == bfsa_pkg::STATUS_NOFIT)
			nofit_seen++;
		pending_results = {pending_results, r};
		requests_sent++;
	endtask

	// Stop offering and wait until every result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write the disk size while the block is idle.
	task automatic write_disk(logic [bfsa_pkg::SIZE_W-1:0] units);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= units;
		@(posedge clk);
		cfg_we <= 1'b0;
		table_restart(units);
	endtask

	// Random request shaped to the current disk size.
	task automatic random_request(int id_pool);
		logic [bfsa_pkg::ID_W-1:0]   id;
		logic [bfsa_pkg::SIZE_W-1:0] units;
		int                          roll;
		int                          cap;
		roll = $urandom_range(99);
		cap = (disk_units / 6 > 1) ? disk_units / 6 : 1;
		id = (roll < 10) ? bfsa_pkg::ID_W'($urandom_range(1, 255))
			: bfsa_pkg::ID_W'($urandom_range(1, id_pool));
		units = bfsa_pkg::SIZE_W'($urandom_range(1, cap));
		if (roll < 3)
			id = '0;
		else if (roll < 5)
			units = '0;
		else if (roll < 9)
			units = bfsa_pkg::SIZE_W'($urandom_range(1, 65535));
		if ($urandom_range(99) < 40)
			send_request(bfsa_pkg::KIND_DELETE, id, bfsa_pkg::SIZE_W'($urandom));
		else
			send_request(bfsa_pkg::KIND_CREATE, id, units);
	endtask

	// Extremes of fields and special cases of create and delete.
	task automatic test_directed();
		send_request(bfsa_pkg::KIND_CREATE, 8'd0, 16'd5);
		send_request(bfsa_pkg::KIND_CREATE, 8'd3, 16'd0);
		send_request(bfsa_pkg::KIND_CREATE, 8'd255, 16'd1000);
		send_request(bfsa_pkg::KIND_CREATE, 8'd1, 16'd1);
		send_request(bfsa_pkg::KIND_DELETE, 8'd255, 16'hFFFF);
		send_request(bfsa_pkg::KIND_CREATE, 8'd1, 16'd65535);
		send_request(bfsa_pkg::KIND_CREATE, 8'd1, 16'd10);
		send_request(bfsa_pkg::KIND_CREATE, 8'd1, 16'd20);
		send_request(bfsa_pkg::KIND_CREATE, 8'd2, 16'd30);
		send_request(bfsa_pkg::KIND_DELETE, 8'd7, 16'd0);
		send_request(bfsa_pkg::KIND_DELETE, 8'd1, 16'd0);
		send_request(bfsa_pkg::KIND_DELETE, 8'd0, 16'd0);
		send_request(bfsa_pkg::KIND_DELETE, 8'd1, 16'd0);
		send_request(bfsa_pkg::KIND_CREATE, 8'd170, 16'd5);
		send_request(bfsa_pkg::KIND_DELETE, 8'd2, 16'd0);
		write_disk(16'd0);
		send_request(bfsa_pkg::KIND_CREATE, 8'd1, 16'd1);
		send_request(bfsa_pkg::KIND_DELETE, 8'd1, 16'd0);
		write_disk(16'hFFFF);
		send_request(bfsa_pkg::KIND_CREATE, 8'd85, 16'hFFFF);
		send_request(bfsa_pkg::KIND_CREATE, 8'd86, 16'd1);
		send_request(bfsa_pkg::KIND_DELETE, 8'd85, 16'd0);
	endtask

	// Fill the table, then check exact fit and the table-full refusal.
	task automatic test_table_full();
		write_disk(16'd200);
		for (int k = 1; k < bfsa_pkg::SEG_DEPTH; k++)
			send_request(bfsa_pkg::KIND_CREATE, bfsa_pkg::ID_W'(k), 16'd1);
		send_request(bfsa_pkg::KIND_CREATE, 8'd99, 16'd2);
		send_request(bfsa_pkg::KIND_DELETE, 8'd5, 16'd0);
		send_request(bfsa_pkg::KIND_CREATE, 8'd200, 16'd1);
		send_request(bfsa_pkg::KIND_CREATE, 8'd201, 16'd300);
		send_request(bfsa_pkg::KIND_DELETE, 8'd200, 16'd0);
		send_request(bfsa_pkg::KIND_DELETE, 8'd6, 16'd0);
		send_request(bfsa_pkg::KIND_CREATE, 8'd202, 16'd2);
	endtask

	// Random phases over several disk sizes.
	task automatic test_random();
		logic [bfsa_pkg::SIZE_W-1:0] sizes[6];
		sizes = '{16'd1, 16'hFFFF, 16'd1000, 16'd64, 16'($urandom_range(2, 65535)), 16'd400};
		for (int p = 0; p < 6; p++) begin
			write_disk(sizes[p]);
			gaps_on = (p != 2);
			stalls_on = (p != 2);
			for (int n = 0; n < 250; n++)
				random_request((p % 2) ? 12 : 40);
		end
		gaps_on = 1;
		stalls_on = 1;
	endtask

	// Receiver holds off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		write_disk(16'd5000);
		hold_left = 600;
		for (int n = 0; n < 40; n++)
			random_request(10);
	endtask

	// Output side stall pattern, with a counted hold-off on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= stalls_on && ($urandom_range(99) < 25);
			end
		end
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d free_total %0d", status, free_total);
				error_count++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					error_count++;
				end
				if (free_total !== e.free_total) begin
					$error("free_total: expected %0d, got %0d", e.free_total, free_total);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_best_fit_segment_allocator_core: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		kind = bfsa_pkg::KIND_CREATE;
		file_id = '0;
		file_size = '0;
		error_count = 0;
		requests_sent = 0;
		results_seen = 0;
		full_seen = 0;
		nofit_seen = 0;
		hold_left = 0;
		idle_cycles = 0;
		gaps_on = 1;
		stalls_on = 1;
		table_restart(bfsa_pkg::RESET_DISK);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_random();
		test_backpressure();
		drain();
		$display("Covered %0d requests and %0d results over several disk sizes;",
			requests_sent, results_seen);
		$display("%0d no-fit and %0d table-full refusals seen.", nofit_seen, full_seen);
		if (error_count == 0) begin
			$display("tb_best_fit_segment_allocator_core: PASS");
		end else begin
			$display("tb_best_fit_segment_allocator_core: FAIL");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/bfsa_pkg.sv
hw/rtl/bfsa_ram.sv
hw/rtl/best_fit_segment_allocator_core.sv
dv/tb_best_fit_segment_allocator_core.sv
